// File: src/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// Logo pixel format convert package
// Shared types and constants for the per-channel lanes and the output merge.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    localparam int IN_W         = 32;
    localparam int LVL_W        = 16;
    localparam int DEP_W        = 15;
    localparam int DIV_STEPS    = 31;
    localparam int LVL_STEPS    = 15;
    // Stage 0 prepares, DIV_STEPS divide, then map, line, check, depth stages
    // and the level divide.
    localparam int ST_LAST      = DIV_STEPS + 4 + LVL_STEPS;
    localparam int S_TDATA_W    = 6 * IN_W;
    localparam int M_FIELDS_W   = 3 * (LVL_W + DEP_W);
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int DP_SCALE_DEF = 1000;

    localparam logic [7:0] REF_LUMA_LO   = 8'd16;
    localparam logic [7:0] REF_LUMA_HI   = 8'd125;
    localparam logic [7:0] REF_CHROMA_LO = 8'd128;
    localparam logic [7:0] REF_CHROMA_HI = 8'd240;

    // One channel's result word, level in the low bits.
    typedef struct packed {
        logic signed [DEP_W-1:0] depth;
        logic signed [LVL_W-1:0] level;
    } chan_t;

endpackage

// File: src/lpfc_lane.sv
// ----------------------------------------------------------------------------
// Logo pixel format convert lane
// Pipelined conversion of one channel's gain and offset into level and depth.
// ----------------------------------------------------------------------------
module lpfc_lane #(
    parameter logic [7:0] REF0     = lpfc_pkg::REF_LUMA_LO,
    parameter logic [7:0] REF1     = lpfc_pkg::REF_LUMA_HI,
    parameter bit         LUMA     = 1'b1,
    parameter int         DP_SCALE = lpfc_pkg::DP_SCALE_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [lpfc_pkg::IN_W-1:0]    alpha,
    input  logic signed [lpfc_pkg::IN_W-1:0]    offset,
    output lpfc_pkg::chan_t                     result
);
    import lpfc_pkg::*;

    localparam logic signed [41:0] DPK       = 42'(DP_SCALE);
    localparam logic [42:0]        DEP_LIMIT = 43'(16383 * 4096);
    localparam logic [57:0]        LVL_MAX   = 58'd32767;

    function automatic logic signed [39:0] map_y(input logic signed [31:0] k);
        logic signed [42:0] pl;
        logic signed [46:0] pc;
        pl = 43'(k) * 43'sd1197;
        pc = (47'(k) - 47'sd128) * 47'sd4681 + 47'sd164;
        if (LUMA)
            map_y = 40'(pl >>> 6) - 40'sd299;
        else
            map_y = 40'(pc >>> 8);
    endfunction

    function automatic logic signed [31:0] sat_k(input logic [30:0] q, input logic neg,
                                                 input logic ovf);
        logic signed [31:0] qs;
        qs = $signed({1'b0, q});
        if (ovf)
            sat_k = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else
            sat_k = neg ? -qs : qs;
    endfunction

    // Front stage: numerators for both reference codes and divisor magnitude.
    logic signed [41:0] off_x, sub, num0, num1;
    logic [40:0]        mag0, mag1;
    logic [31:0]        amag;
    logic               ovf0, ovf1;

    always_comb
    begin
        off_x = 42'(offset);
        sub   = (off_x <<< 8) - off_x;
        num0  = $signed(42'({REF0, 16'd0})) - sub;
        num1  = $signed(42'({REF1, 16'd0})) - sub;
        mag0  = num0[41] ? 41'(-num0) : 41'(num0);
        mag1  = num1[41] ? 41'(-num1) : 41'(num1);
        amag  = alpha[31] ? 32'(-alpha) : 32'(alpha);
        ovf0  = 63'(mag0) >= {amag, 31'd0};
        ovf1  = 63'(mag1) >= {amag, 31'd0};
    end

    logic [40:0] r0_reg [0:DIV_STEPS];
    logic [40:0] r1_reg [0:DIV_STEPS];
    logic [30:0] q0_reg [0:DIV_STEPS];
    logic [30:0] q1_reg [0:DIV_STEPS];
    logic [31:0] dv_reg [0:DIV_STEPS];
    logic        n0_reg [0:DIV_STEPS];
    logic        n1_reg [0:DIV_STEPS];
    logic        o0_reg [0:DIV_STEPS];
    logic        o1_reg [0:DIV_STEPS];
    logic        z_reg  [0:DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg[0] <= mag0;
            r1_reg[0] <= mag1;
            q0_reg[0] <= '0;
            q1_reg[0] <= '0;
            dv_reg[0] <= amag;
            n0_reg[0] <= num0[41] ^ alpha[31];
            n1_reg[0] <= num1[41] ^ alpha[31];
            o0_reg[0] <= ovf0;
            o1_reg[0] <= ovf1;
            z_reg[0]  <= (alpha == '0);
        end
    end

    // Restoring divide, one quotient bit per stage, both references side by side.
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        logic [62:0] dsh;
        logic        ge0, ge1;

        assign dsh = 63'(dv_reg[j]) << B;
        assign ge0 = 63'(r0_reg[j]) >= dsh;
        assign ge1 = 63'(r1_reg[j]) >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r0_reg[j+1] <= ge0 ? 41'(63'(r0_reg[j]) - dsh) : r0_reg[j];
                r1_reg[j+1] <= ge1 ? 41'(63'(r1_reg[j]) - dsh) : r1_reg[j];
                q0_reg[j+1] <= {q0_reg[j][29:0], ge0};
                q1_reg[j+1] <= {q1_reg[j][29:0], ge1};
                dv_reg[j+1] <= dv_reg[j];
                n0_reg[j+1] <= n0_reg[j];
                n1_reg[j+1] <= n1_reg[j];
                o0_reg[j+1] <= o0_reg[j];
                o1_reg[j+1] <= o1_reg[j];
                z_reg[j+1]  <= z_reg[j];
            end
        end
    end

    // Mapping into the wide colour code.
    logic signed [39:0] ym0_reg, ym1_reg;
    logic               zm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ym0_reg <= map_y(sat_k(q0_reg[DIV_STEPS], n0_reg[DIV_STEPS], o0_reg[DIV_STEPS]));
            ym1_reg <= map_y(sat_k(q1_reg[DIV_STEPS], n1_reg[DIV_STEPS], o1_reg[DIV_STEPS]));
            zm_reg  <= z_reg[DIV_STEPS];
        end
    end

    // Line through both points: level numerator and denominator.
    logic signed [41:0] d, dab;
    logic signed [53:0] n;
    logic signed [42:0] m;
    logic [53:0]        an_d;

    always_comb
    begin
        d   = 42'sd2048 - 42'(ym1_reg) + 42'(ym0_reg);
        n   = (54'(ym0_reg) <<< 12) + 54'(d);
        m   = 43'(d) <<< 1;
        dab = d[41] ? -d : d;
        if (m[42])
        begin
            n = -n;
            m = -m;
        end
        an_d = n[53] ? 54'(-n) : 54'(n);
    end

    logic [53:0]        an_c_reg;
    logic [42:0]        mp_c_reg;
    logic               qn_c_reg, rj_c_reg, db_c_reg;
    logic signed [26:0] dsm_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_c_reg  <= an_d;
            mp_c_reg  <= 43'(m);
            qn_c_reg  <= n[53];
            rj_c_reg  <= zm_reg | (d == '0);
            // Above this the depth cannot pass for any scale.
            db_c_reg  <= (dab[41:26] != '0);
            dsm_c_reg <= d[26:0];
        end
    end

    // Level range check and depth product.
    logic               lok;
    logic [53:0]        an_e_reg;
    logic [42:0]        mp_e_reg;
    logic               qn_e_reg, rj_e_reg;
    logic signed [41:0] p_e_reg;

    assign lok = {4'd0, an_c_reg} < ((58'(mp_c_reg) << 15) - 58'(mp_c_reg) * (LVL_MAX - 58'd32767 + 58'd1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_e_reg <= an_c_reg;
            mp_e_reg <= mp_c_reg;
            qn_e_reg <= qn_c_reg;
            rj_e_reg <= rj_c_reg | db_c_reg | !lok;
            p_e_reg  <= 42'(dsm_c_reg) * DPK;
        end
    end

    // Depth rounding and range check.
    logic signed [42:0]      nd;
    logic [42:0]             ndab;
    logic                    dok;
    logic [DEP_W-1:0]        dq;
    logic signed [DEP_W-1:0] dep;

    always_comb
    begin
        nd   = (43'(p_e_reg) <<< 1) + 43'sd2048;
        ndab = nd[42] ? 43'(-nd) : 43'(nd);
        dok  = (ndab <= DEP_LIMIT) && (ndab >= 43'd4096);
        dq   = DEP_W'(ndab >> 12);
        dep  = nd[42] ? -$signed(dq) : $signed(dq);
    end

    logic [53:0]             lr_reg [0:LVL_STEPS];
    logic [LVL_STEPS-1:0]    lq_reg [0:LVL_STEPS];
    logic [42:0]             lm_reg [0:LVL_STEPS];
    logic                    ln_reg [0:LVL_STEPS];
    logic                    lj_reg [0:LVL_STEPS];
    logic signed [DEP_W-1:0] ld_reg [0:LVL_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lr_reg[0] <= an_e_reg;
            lq_reg[0] <= '0;
            lm_reg[0] <= mp_e_reg;
            ln_reg[0] <= qn_e_reg;
            lj_reg[0] <= rj_e_reg | !dok;
            ld_reg[0] <= dep;
        end
    end

    // The range check keeps the level quotient within 15 bits.
    for (genvar j = 0; j < LVL_STEPS; j++)
    begin : g_lvl
        localparam int B = LVL_STEPS - 1 - j;
        logic [57:0] msh;
        logic        ge;

        assign msh = 58'(lm_reg[j]) << B;
        assign ge  = 58'(lr_reg[j]) >= msh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lr_reg[j+1] <= ge ? 54'(58'(lr_reg[j]) - msh) : lr_reg[j];
                lq_reg[j+1] <= {lq_reg[j][LVL_STEPS-2:0], ge};
                lm_reg[j+1] <= lm_reg[j];
                ln_reg[j+1] <= ln_reg[j];
                lj_reg[j+1] <= lj_reg[j];
                ld_reg[j+1] <= ld_reg[j];
            end
        end
    end

    logic signed [LVL_W-1:0] lq_s;

    always_comb
    begin
        lq_s = $signed(LVL_W'(lq_reg[LVL_STEPS]));
        if (lj_reg[LVL_STEPS])
        begin
            result.level = '0;
            result.depth = '0;
        end
        else
        begin
            result.level = ln_reg[LVL_STEPS] ? -lq_s : lq_s;
            result.depth = ld_reg[LVL_STEPS];
        end
    end

endmodule

// File: src/lpfc_merge.sv
// ----------------------------------------------------------------------------
// Logo pixel format convert merge
// Joins the three lane results into one output word, with a skid register.
// ----------------------------------------------------------------------------
module lpfc_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  lpfc_pkg::chan_t                   luma,
    input  lpfc_pkg::chan_t                   cb,
    input  lpfc_pkg::chan_t                   cr,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [lpfc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              skid_full
);
    import lpfc_pkg::*;

    logic [M_TDATA_W-1:0] word;
    logic [M_TDATA_W-1:0] out_reg, skid_reg;
    logic                 out_v_reg, skid_v_reg;
    logic                 incoming;

    assign word     = M_TDATA_W'({cr, cb, luma});
    assign incoming = in_valid && !skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_v_reg && !m_tready)
        begin
            if (incoming)
                skid_v_reg <= 1'b1;
        end
        else if (skid_v_reg)
        begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= incoming;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_v_reg && !m_tready)
        begin
            if (incoming)
                skid_reg <= word;
        end
        else if (skid_v_reg)
            out_reg <= skid_reg;
        else
            out_reg <= word;
    end

    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_reg;
    assign skid_full = skid_v_reg;

endmodule

// File: src/logo_pixel_format_convert.sv
// ----------------------------------------------------------------------------
// Logo pixel format convert
// Turns one pixel's luma and chroma blend model into logo levels and depths.
// ----------------------------------------------------------------------------
// One pixel is taken every cycle while the skid register is not full. Its result
// word passes the two restoring dividers in each lane, which resolve one quotient
// bit per pipeline stage (31 stages for the gain divide and 15 for the level
// divide), and is registered at the output. The three channels run in separate
// lanes side by side and a skid register at the output lets the pipeline keep
// moving for one word while the downstream side stalls.
module logo_pixel_format_convert #(
    parameter int DP_SCALE = lpfc_pkg::DP_SCALE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // alpha_luma, offset_luma, alpha_cb, offset_cb, alpha_cr, offset_cr
    input  logic [lpfc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // luma_level, luma_depth, cb_level, cb_depth, cr_level, cr_depth, zero pad
    output logic [lpfc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import lpfc_pkg::*;

    logic             en, skid_full;
    logic [ST_LAST:0] v_reg;
    chan_t            luma_res, cb_res, cr_res;

    assign en       = !skid_full;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[ST_LAST-1:0], s_tvalid};
    end

    lpfc_lane #(
        .REF0(REF_LUMA_LO), .REF1(REF_LUMA_HI), .LUMA(1'b1), .DP_SCALE(DP_SCALE)
    ) u_luma (
        .clk(clk), .en(en),
        .alpha($signed(s_tdata[31:0])), .offset($signed(s_tdata[63:32])),
        .result(luma_res)
    );

    lpfc_lane #(
        .REF0(REF_CHROMA_LO), .REF1(REF_CHROMA_HI), .LUMA(1'b0), .DP_SCALE(DP_SCALE)
    ) u_cb (
        .clk(clk), .en(en),
        .alpha($signed(s_tdata[95:64])), .offset($signed(s_tdata[127:96])),
        .result(cb_res)
    );

    lpfc_lane #(
        .REF0(REF_CHROMA_LO), .REF1(REF_CHROMA_HI), .LUMA(1'b0), .DP_SCALE(DP_SCALE)
    ) u_cr (
        .clk(clk), .en(en),
        .alpha($signed(s_tdata[159:128])), .offset($signed(s_tdata[191:160])),
        .result(cr_res)
    );

    lpfc_merge u_merge (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v_reg[ST_LAST]),
        .luma(luma_res), .cb(cb_res), .cr(cr_res),
        .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata),
        .skid_full(skid_full)
    );

    // The skid register only fills behind a held output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full |-> m_tvalid) else $error("skid full with no output word");

    a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full) |-> $past(m_tvalid && !m_tready))
        else $error("skid filled without a stall");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0))
        else $error("padding bits set");

    // An accepted channel always has a non-zero depth; checked here for luma and cb.
    a_luma_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[30:16] == '0) |-> (m_tdata[15:0] == '0))
        else $error("luma level without depth");

    a_cb_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[61:47] == '0) |-> (m_tdata[46:31] == '0))
        else $error("cb level without depth");

endmodule

// File: test/tb_logo_pixel_format_convert.sv
// ----------------------------------------------------------------------------
// Logo pixel format convert testbench
// Streams blend models through the converter with random idling on both sides
// and checks every output word against an in-bench integer model of the block.
// ----------------------------------------------------------------------------
module tb_logo_pixel_format_convert;

    timeunit 1ns;
    timeprecision 1ps;

    import lpfc_pkg::*;

    localparam int  N_RANDOM   = 1530;
    localparam int  DRAIN_WAIT = 120;
    localparam int  CYCLE_CAP  = 400000;
    localparam longint LVL_MAX = 32'h7FFF;
    localparam longint DEP_MAX = 32'h3FFF;

    typedef struct packed {
        chan_t cr;
        chan_t cb;
        chan_t luma;
    } pixel_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    logic [S_TDATA_W-1:0]   models_pending[$];
    pixel_t                 pixels_due[$];
    int                     words_in;
    int                     words_out;
    int                     mismatches;
    int                     cycles;
    int                     send_gap;
    int                     recv_gap;
    int                     hold_left;
    bit                     hold_done;

    logo_pixel_format_convert dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic longint div_floor(longint n, longint d);
        longint q;
        begin
            q = n / d;
            if ((n % d) != 0 && n < 0)
                q = q - 1;
            return q;
        end
    endfunction

    // Maps one reference code through the channel's line into the wide code.
    function automatic longint wide_code(longint code, longint gain, longint offs, bit luma);
        longint k;
        begin
            k = (code * 65536 - 255 * offs) / gain;
            if (k > 64'sd2147483647)
                k = 64'sd2147483647;
            if (k < -64'sd2147483648)
                k = -64'sd2147483648;
            if (luma)
                return div_floor(k * 1197, 64) - 299;
            return div_floor((k - 128) * 4681 + 164, 256);
        end
    endfunction

    function automatic chan_t blend_channel(logic signed [31:0] gain_in,
                                            logic signed [31:0] offs_in, bit luma);
        chan_t  res;
        longint gain;
        longint offs;
        longint y0;
        longint y1;
        longint d;
        longint n;
        longint m;
        longint nd;
        begin
            res  = '0;
            gain = gain_in;
            offs = offs_in;
            if (gain == 0)
                return res;
            y0 = wide_code(luma ? REF_LUMA_LO : REF_CHROMA_LO, gain, offs, luma);
            y1 = wide_code(luma ? REF_LUMA_HI : REF_CHROMA_HI, gain, offs, luma);
            d  = 2048 - y1 + y0;
            if (d == 0)
                return res;
            n = 4096 * y0 + d;
            m = 2 * d;
            if (m < 0)
            begin
                n = -n;
                m = -m;
            end
            if (!((n < 0 ? -n : n) < LVL_MAX * m))
                return res;
            nd = 2 * d * 1000 + 2048;
            if ((nd < 0 ? -nd : nd) > DEP_MAX * 4096 || (nd < 0 ? -nd : nd) < 4096)
                return res;
            res.level = LVL_W'(n / m);
            res.depth = DEP_W'(nd / 4096);
            return res;
        end
    endfunction

    function automatic pixel_t blend_pixel(logic [S_TDATA_W-1:0] model);
        pixel_t p;
        begin
            p.luma = blend_channel(model[31:0],    model[63:32],   1'b1);
            p.cb   = blend_channel(model[95:64],   model[127:96],  1'b0);
            p.cr   = blend_channel(model[159:128], model[191:160], 1'b0);
            return p;
        end
    endfunction

    // Mostly short gaps, a few long ones, and whole stretches with none.
    function automatic int pick_gap(int count);
        int r;
        begin
            if ((count / 128) % 3 == 0)
                return 0;
            r = $urandom_range(0, 99);
            if (r < 60)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'(int'($urandom_range(0, 262144)) - 131072);
            2: return 32'(int'($urandom_range(60000, 71000)) * ($urandom_range(0, 1) ? 1 : -1));
            default: return 32'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic logic [31:0] random_offset();
        case ($urandom_range(0, 2))
            0: return $urandom();
            1: return 32'(int'($urandom_range(0, 131072)) - 65536);
            default: return 32'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic queue_model(logic [31:0] ga, logic [31:0] oa, logic [31:0] gb,
                               logic [31:0] ob, logic [31:0] gc, logic [31:0] oc);
        models_pending.push_back({oc, gc, ob, gb, oa, ga});
    endtask

    // Sender: one word per handshake, refilled only when the bus is free.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap = 0;
            words_in = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pixels_due.push_back(blend_pixel(s_tdata));
                words_in++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (models_pending.size() > 0)
                begin
                    s_tdata  <= models_pending.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap(words_in);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each word, stalls at random and once for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
            hold_done = 1'b0;
            words_out = 0;
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = pixel_t'(m_tdata[M_FIELDS_W-1:0]);
                if (pixels_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Unexpected output word %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (got != want || m_tdata[M_TDATA_W-1:M_FIELDS_W] != '0)
                    begin
                        if (mismatches < 10)
                            $display("Word %0d: luma %0d/%0d cb %0d/%0d cr %0d/%0d, got luma %0d/%0d cb %0d/%0d cr %0d/%0d",
                                     words_out, want.luma.level, want.luma.depth,
                                     want.cb.level, want.cb.depth, want.cr.level,
                                     want.cr.depth, got.luma.level, got.luma.depth,
                                     got.cb.level, got.cb.depth, got.cr.level,
                                     got.cr.depth);
                        mismatches++;
                    end
                end
                words_out++;
            end
            if (!hold_done && words_in >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap = pick_gap(words_out + 64);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;

        // Zero gain, unit gain, field extremes and saturation of the scaled value.
        queue_model(32'd0, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd0, 32'h80000000);
        queue_model(32'd65536, 32'd0, 32'd65536, 32'd0, 32'd65536, 32'd0);
        queue_model(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                    32'hFFFFFFFF, 32'd0);
        queue_model(32'd1, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF,
                    32'd1, 32'h7FFFFFFF);
        queue_model(32'h80000000, 32'd0, 32'd1, 32'd0, 32'h7FFFFFFF, 32'h80000000);
        queue_model(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
                    32'h80000000, 32'hFFFFFFFF);
        queue_model(32'd70000, 32'd1000, 32'd60000, -32'sd2000, 32'd131072, 32'd30000);
        queue_model(-32'sd65536, 32'd0, -32'sd65536, 32'd65536, -32'sd70000, -32'sd100);
        queue_model(32'd100, 32'd5, 32'd3000, 32'd10, -32'sd500, 32'd0);
        queue_model(32'd65535, 32'd1, 32'd65537, -32'sd1, 32'd65536, 32'd65536);
        queue_model(32'd2, 32'd0, 32'd2, 32'd0, -32'sd2, 32'd0);
        queue_model(32'd1000000, -32'sd1000000, 32'd100000000, 32'd0,
                    -32'sd100000000, 32'd12345678);

        #1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Let the directed words drain completely before the random part.
        wait (models_pending.size() == 0 && !s_tvalid && pixels_due.size() == 0);
        @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
            queue_model(random_gain(), random_offset(), random_gain(),
                        random_offset(), random_gain(), random_offset());

        wait (models_pending.size() == 0 && !s_tvalid && pixels_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
